>>> rtl/core/abpg_pkg.sv
// Shared types and constants for the alert beep pattern generator.
package abpg_pkg;

    // Alert modes; MODE_NONE is the reset code so the first sample counts as a change
    typedef enum logic [2:0] {
        MODE_SILENT   = 3'd0,
        MODE_ALARM    = 3'd1,
        MODE_APPROACH = 3'd2,
        MODE_NORMAL   = 3'd3,
        MODE_NONE     = 3'd4
    } t_mode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FORCE_ENABLE = 2'd0,
        CFG_FAST_SPEED   = 2'd1,
        CFG_MID_SPEED    = 2'd2,
        CFG_APPROACH_WIN = 2'd3
    } t_cfg_index;

    localparam logic [15:0] FAST_SPEED_RESET = 16'd2816;  // 11.0 m/s in Q8.8
    localparam logic [15:0] MID_SPEED_RESET  = 16'd2304;  // 9.0 m/s in Q8.8
    localparam logic [15:0] APPROACH_RESET   = 16'd2000;

    localparam logic [31:0] BACKDATE_MS = 32'd10000;

    localparam logic [10:0] FREQ_ALARM = 11'd1760;
    localparam logic [10:0] FREQ_FAST  = 11'd1320;
    localparam logic [10:0] FREQ_MID   = 11'd880;
    localparam logic [10:0] FREQ_SLOW  = 11'd440;

    localparam logic [9:0] ALARM_ON_MS     = 10'd120;
    localparam logic [9:0] ALARM_OFF_MS    = 10'd120;
    localparam logic [9:0] APPROACH_ON_MS  = 10'd150;
    localparam logic [9:0] APPROACH_OFF_MS = 10'd150;
    localparam logic [9:0] NORMAL_ON_MS    = 10'd300;
    localparam logic [9:0] NORMAL_OFF_MS   = 10'd600;

    // Configuration registers
    typedef struct packed {
        logic        force_enable;
        logic [15:0] fast_speed_threshold;
        logic [15:0] mid_speed_threshold;
        logic [15:0] approach_window_ms;
    } t_cfg;

    // Per-sample state carried between items
    typedef struct packed {
        t_mode       prev_mode;
        logic        sounding;
        logic [31:0] last_toggle_ms;
        logic [10:0] held_freq;
    } t_state;

    // One sample
    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] air_speed;
        logic        took_off;
        logic        in_permitted_area;
        logic [31:0] time_to_boundary_ms;
    } t_sample;

    // One result
    typedef struct packed {
        logic        tone_on;
        logic [10:0] tone_freq_hz;
        logic [1:0]  alert_mode;
    } t_result;

endpackage

>>> rtl/core/alert_beep_pattern_generator_unit.sv
// Top level of the alert beep pattern generator: handshakes, registers, config.
//
// Takes one sample per clock and returns one result per sample. A sample is
// captured in an input register on its transfer; the next cycle the mode
// choice and tone timing are computed from it and the stored tone state, and
// the result lands in an output register once the output side is free.
// Throughput is one sample per cycle, limited only by the output side
// taking results; the input register refills while a result waits.
// Configuration writes are registered and always accepted.
module alert_beep_pattern_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_air_speed,
    input  logic        i_took_off,
    input  logic        i_in_permitted_area,
    input  logic [31:0] i_time_to_boundary_ms,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tone_on,
    output logic [10:0] o_tone_freq_hz,
    output logic [1:0]  o_alert_mode,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    abpg_pkg::t_cfg    r_cfg;
    abpg_pkg::t_state  r_state;
    abpg_pkg::t_state  n_state;
    abpg_pkg::t_sample r_in;
    logic              r_in_valid;
    abpg_pkg::t_result r_out;
    abpg_pkg::t_result n_out;
    logic              r_out_valid;
    logic              out_free;
    logic              advance;

    // Handshake control
    assign out_free    = !r_out_valid || i_ready;
    assign advance     = r_in_valid && out_free;
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.force_enable         <= 1'b0;
            r_cfg.fast_speed_threshold <= abpg_pkg::FAST_SPEED_RESET;
            r_cfg.mid_speed_threshold  <= abpg_pkg::MID_SPEED_RESET;
            r_cfg.approach_window_ms   <= abpg_pkg::APPROACH_RESET;
        end else if (i_cfg_valid) begin
            unique case (abpg_pkg::t_cfg_index'(i_cfg_index))
                abpg_pkg::CFG_FORCE_ENABLE: r_cfg.force_enable         <= i_cfg_data[0];
                abpg_pkg::CFG_FAST_SPEED:   r_cfg.fast_speed_threshold <= i_cfg_data;
                abpg_pkg::CFG_MID_SPEED:    r_cfg.mid_speed_threshold  <= i_cfg_data;
                abpg_pkg::CFG_APPROACH_WIN: r_cfg.approach_window_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.now_ms              <= i_now_ms;
            r_in.air_speed           <= i_air_speed;
            r_in.took_off            <= i_took_off;
            r_in.in_permitted_area   <= i_in_permitted_area;
            r_in.time_to_boundary_ms <= i_time_to_boundary_ms;
        end
    end

    // Per-sample update logic
    abpg_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Tone state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_mode      <= abpg_pkg::MODE_NONE;
            r_state.sounding       <= 1'b0;
            r_state.last_toggle_ms <= 32'd0;
            r_state.held_freq      <= 11'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tone_on      = r_out.tone_on;
    assign o_tone_freq_hz = r_out.tone_freq_hz;
    assign o_alert_mode   = r_out.alert_mode;

    // Silent mode never leaves the tone on
    a_silent_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.prev_mode == abpg_pkg::MODE_SILENT) |-> !r_state.sounding)
        else $error("tone on in silent mode");

    // A muted result carries no frequency
    a_mute_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tone_on) |-> (o_tone_freq_hz == 11'd0))
        else $error("frequency set while tone off");

    // Alarm tone is always the alarm frequency
    a_alarm_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tone_on && (o_alert_mode == 2'(abpg_pkg::MODE_ALARM)))
        |-> (o_tone_freq_hz == abpg_pkg::FREQ_ALARM))
        else $error("alarm tone at wrong frequency");

    // A sample leaving the input stage always produces a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after input stage");

endmodule

>>> rtl/core/abpg_step.sv
// Combinational per-sample update: mode choice, tone toggle timing and result.
module abpg_step (
    input  abpg_pkg::t_cfg    i_cfg,
    input  abpg_pkg::t_state  i_state,
    input  abpg_pkg::t_sample i_sample,
    output abpg_pkg::t_state  o_state,
    output abpg_pkg::t_result o_result
);

    abpg_pkg::t_mode mode;
    logic            approaching;
    logic [10:0]     band_freq;
    logic [10:0]     freq;
    logic [9:0]      on_ms;
    logic [9:0]      off_ms;
    logic            eff_sounding;
    logic [31:0]     eff_last;
    logic [31:0]     elapsed;
    logic            do_on;
    logic            do_off;

    // Boundary is ahead and inside the window (positive and below it)
    assign approaching = !i_sample.time_to_boundary_ms[31]
                      && (i_sample.time_to_boundary_ms != 32'd0)
                      && (i_sample.time_to_boundary_ms
                          < {16'd0, i_cfg.approach_window_ms});

    // Mode choice
    always_comb begin
        if (i_sample.took_off || i_cfg.force_enable) begin
            if (!i_sample.in_permitted_area) begin
                mode = abpg_pkg::MODE_ALARM;
            end else if (approaching) begin
                mode = abpg_pkg::MODE_APPROACH;
            end else begin
                mode = abpg_pkg::MODE_NORMAL;
            end
        end else begin
            mode = abpg_pkg::MODE_SILENT;
        end
    end

    // Airspeed band; fast test first even if thresholds cross
    always_comb begin
        if (i_sample.air_speed >= i_cfg.fast_speed_threshold) begin
            band_freq = abpg_pkg::FREQ_FAST;
        end else if (i_sample.air_speed >= i_cfg.mid_speed_threshold) begin
            band_freq = abpg_pkg::FREQ_MID;
        end else begin
            band_freq = abpg_pkg::FREQ_SLOW;
        end
    end

    // Per-mode tone and durations
    always_comb begin
        case (mode)
            abpg_pkg::MODE_ALARM: begin
                freq   = abpg_pkg::FREQ_ALARM;
                on_ms  = abpg_pkg::ALARM_ON_MS;
                off_ms = abpg_pkg::ALARM_OFF_MS;
            end
            abpg_pkg::MODE_APPROACH: begin
                freq   = band_freq;
                on_ms  = abpg_pkg::APPROACH_ON_MS;
                off_ms = abpg_pkg::APPROACH_OFF_MS;
            end
            default: begin
                freq   = band_freq;
                on_ms  = abpg_pkg::NORMAL_ON_MS;
                off_ms = abpg_pkg::NORMAL_OFF_MS;
            end
        endcase
    end

    // Mode change stops the tone and backdates the timer
    always_comb begin
        if (mode != i_state.prev_mode) begin
            eff_sounding = 1'b0;
            eff_last     = i_sample.now_ms - abpg_pkg::BACKDATE_MS;
        end else begin
            eff_sounding = i_state.sounding;
            eff_last     = i_state.last_toggle_ms;
        end
    end

    // Wrapping elapsed time, strict compare
    assign elapsed = i_sample.now_ms - eff_last;
    assign do_on   = (mode != abpg_pkg::MODE_SILENT) && !eff_sounding
                  && (elapsed > {22'd0, off_ms});
    assign do_off  = (mode != abpg_pkg::MODE_SILENT) && eff_sounding
                  && (elapsed > {22'd0, on_ms});

    // Next state
    always_comb begin
        o_state.prev_mode      = mode;
        o_state.held_freq      = do_on ? freq : i_state.held_freq;
        o_state.last_toggle_ms = (do_on || do_off) ? i_sample.now_ms : eff_last;
        if (mode == abpg_pkg::MODE_SILENT) begin
            o_state.sounding = 1'b0;
        end else if (do_on) begin
            o_state.sounding = 1'b1;
        end else if (do_off) begin
            o_state.sounding = 1'b0;
        end else begin
            o_state.sounding = eff_sounding;
        end
    end

    // Result
    always_comb begin
        o_result.tone_on      = o_state.sounding;
        o_result.tone_freq_hz = o_state.sounding ? o_state.held_freq : 11'd0;
        o_result.alert_mode   = mode[1:0];
    end

endmodule
